/* sv/thb_pkg.sv */
// Shared constants and transaction types for the threshold bin histogram.
`default_nettype none

package thb_pkg;

    localparam int NUM_BINS   = 8;
    localparam int BIN_W      = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam int NUM_LIMITS = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int LIMIT_W    = 41;
    localparam int AMOUNT_W   = 40;
    localparam int COUNT_W    = 32;
    localparam int BYTE_W     = 48;
    localparam int TIME_W     = 32;
    localparam int IDX_OUT_W  = 3;

    typedef struct packed {
        logic [AMOUNT_W-1:0] amount;
        logic                recent_flag;
        logic                page_flag;
        logic                recent_page_flag;
        logic [AMOUNT_W-1:0] byte_add;
        logic [AMOUNT_W-1:0] recent_byte_add;
        logic [TIME_W-1:0]   time_code;
    } req_t;

    typedef struct packed {
        logic [IDX_OUT_W-1:0] bin_index;
        logic [COUNT_W-1:0]   request_count;
        logic [COUNT_W-1:0]   recent_request_count;
        logic [COUNT_W-1:0]   page_count;
        logic [COUNT_W-1:0]   recent_page_count;
        logic [BYTE_W-1:0]    byte_total;
        logic [BYTE_W-1:0]    recent_byte_total;
        logic [TIME_W-1:0]    latest_time;
        logic [TIME_W-1:0]    earliest_time;
    } res_t;

    // Transaction as it walks the cell row; done marks it as already binned.
    typedef struct packed {
        req_t req;
        logic done;
        res_t res;
    } token_t;

endpackage

`default_nettype wire

/* sv/threshold_bin_histogram.sv */
// Top level of the threshold bin histogram: limit registers and the row of bin cells.
//
// Usage:
//   s_* is the event channel (valid/ready); each transaction carries an amount,
//   three flags, two byte amounts and a time code. m_* returns one result
//   transaction per event: the bin index and that bin's updated totals.
//   cfg_we/cfg_index/cfg_data write the seven bin limits (41-bit signed, any
//   negative value catches all); index 7 is ignored. Write only while idle.
//   Structure: NUM_BINS cells in a row, one per bin, each with a stage
//   register. An event moves one cell per cycle while the next cell is ready;
//   the first cell whose limit covers the amount updates its totals and stamps
//   the result into the transaction, later cells just pass it on. The last
//   cell catches all. The result leaves the last cell's stage register.
//   Throughput: one event per cycle while m_ready is high; cells see events in
//   order, so a bin's totals are always current when the next event reaches it.
//   Stall: each cell's ready is !valid || downstream ready, so bubbles
//   collapse and events keep being accepted until the whole row is full
//   while m_ready is low.
//   Reset: limits go to -1 (catch all), counters to zero, earliest time to
//   all ones, every stage empty. No clearing pass.
`default_nettype none

module threshold_bin_histogram (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // configuration
    input  wire logic                           cfg_we,
    input  wire logic [thb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [thb_pkg::LIMIT_W-1:0]    cfg_data,
    // event transactions
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [thb_pkg::AMOUNT_W-1:0]   s_amount,
    input  wire logic                           s_recent_flag,
    input  wire logic                           s_page_flag,
    input  wire logic                           s_recent_page_flag,
    input  wire logic [thb_pkg::AMOUNT_W-1:0]   s_byte_add,
    input  wire logic [thb_pkg::AMOUNT_W-1:0]   s_recent_byte_add,
    input  wire logic [thb_pkg::TIME_W-1:0]     s_time_code,
    // result transactions
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [thb_pkg::IDX_OUT_W-1:0]       m_bin_index,
    output logic [thb_pkg::COUNT_W-1:0]         m_request_count,
    output logic [thb_pkg::COUNT_W-1:0]         m_recent_request_count,
    output logic [thb_pkg::COUNT_W-1:0]         m_page_count,
    output logic [thb_pkg::COUNT_W-1:0]         m_recent_page_count,
    output logic [thb_pkg::BYTE_W-1:0]          m_byte_total,
    output logic [thb_pkg::BYTE_W-1:0]          m_recent_byte_total,
    output logic [thb_pkg::TIME_W-1:0]          m_latest_time,
    output logic [thb_pkg::TIME_W-1:0]          m_earliest_time
);
    import thb_pkg::*;

    logic [LIMIT_W-1:0] limit_reg [NUM_LIMITS];

    // chain links: link i feeds cell i, link NUM_BINS is the result port
    logic   link_valid [NUM_BINS+1];
    logic   link_ready [NUM_BINS+1];
    token_t link_token [NUM_BINS+1];

    // Limit registers; out-of-range indexes match nothing.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_LIMITS; i++) begin
                limit_reg[i] <= '1;
            end
        end else begin
            for (int i = 0; i < NUM_LIMITS; i++) begin
                if (cfg_we && (cfg_index == CFG_IDX_W'(i))) begin
                    limit_reg[i] <= cfg_data;
                end
            end
        end
    end

    // Incoming transaction, not yet binned.
    always_comb begin
        link_token[0]                      = '0;
        link_token[0].req.amount           = s_amount;
        link_token[0].req.recent_flag      = s_recent_flag;
        link_token[0].req.page_flag        = s_page_flag;
        link_token[0].req.recent_page_flag = s_recent_page_flag;
        link_token[0].req.byte_add         = s_byte_add;
        link_token[0].req.recent_byte_add  = s_recent_byte_add;
        link_token[0].req.time_code        = s_time_code;
        link_token[0].done                 = 1'b0;
    end
    assign link_valid[0] = s_valid;
    assign s_ready       = link_ready[0];

    for (genvar g = 0; g < NUM_BINS; g++) begin : g_cell
        logic [LIMIT_W-1:0] cell_limit;
        logic               cell_catch_all;

        // Last bin, and any bin without a limit register, catches all.
        if ((g < NUM_LIMITS) && (g < NUM_BINS - 1)) begin : g_lim
            assign cell_limit     = limit_reg[g];
            assign cell_catch_all = 1'b0;
        end else begin : g_all
            assign cell_limit     = '1;
            assign cell_catch_all = 1'b1;
        end

        thb_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .limit     (cell_limit),
            .catch_all (cell_catch_all),
            .bin_id    (BIN_W'(g)),
            .in_valid  (link_valid[g]),
            .in_ready  (link_ready[g]),
            .in_token  (link_token[g]),
            .out_valid (link_valid[g+1]),
            .out_ready (link_ready[g+1]),
            .out_token (link_token[g+1])
        );
    end

    assign link_ready[NUM_BINS] = m_ready;
    assign m_valid              = link_valid[NUM_BINS];

    assign m_bin_index            = link_token[NUM_BINS].res.bin_index;
    assign m_request_count        = link_token[NUM_BINS].res.request_count;
    assign m_recent_request_count = link_token[NUM_BINS].res.recent_request_count;
    assign m_page_count           = link_token[NUM_BINS].res.page_count;
    assign m_recent_page_count    = link_token[NUM_BINS].res.recent_page_count;
    assign m_byte_total           = link_token[NUM_BINS].res.byte_total;
    assign m_recent_byte_total    = link_token[NUM_BINS].res.recent_byte_total;
    assign m_latest_time          = link_token[NUM_BINS].res.latest_time;
    assign m_earliest_time        = link_token[NUM_BINS].res.earliest_time;

endmodule

`default_nettype wire

/* sv/thb_cell.sv */
// One histogram bin: limit check, bin totals and the stage register of the row.
`default_nettype none

module thb_cell (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic [thb_pkg::LIMIT_W-1:0]  limit,
    input  wire logic                         catch_all,
    input  wire logic [thb_pkg::BIN_W-1:0]    bin_id,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire thb_pkg::token_t              in_token,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output thb_pkg::token_t                   out_token
);
    import thb_pkg::*;

    logic               vld_reg, vld_next;
    token_t             tok_reg, tok_next;
    logic [COUNT_W-1:0] req_reg, req_next;
    logic [COUNT_W-1:0] rreq_reg, rreq_next;
    logic [COUNT_W-1:0] pg_reg, pg_next;
    logic [COUNT_W-1:0] rpg_reg, rpg_next;
    logic [BYTE_W-1:0]  byt_reg, byt_next;
    logic [BYTE_W-1:0]  rbyt_reg, rbyt_next;
    logic [TIME_W-1:0]  latest_reg, latest_next;
    logic [TIME_W-1:0]  earliest_reg, earliest_next;

    logic               load, takes, claim;
    logic [COUNT_W:0]   req_sum, rreq_sum, pg_sum, rpg_sum;
    logic [BYTE_W:0]    byt_sum, rbyt_sum;
    logic [COUNT_W-1:0] req_upd, rreq_upd, pg_upd, rpg_upd;
    logic [BYTE_W-1:0]  byt_upd, rbyt_upd;
    logic [TIME_W-1:0]  latest_upd, earliest_upd;

    assign in_ready  = !vld_reg || out_ready;
    assign load      = in_valid && in_ready;
    // sign bit of the limit means catch all
    assign takes     = catch_all || limit[LIMIT_W-1] ||
                       (in_token.req.amount <= limit[AMOUNT_W-1:0]);
    assign claim     = load && !in_token.done && takes;

    assign req_sum  = {1'b0, req_reg}  + {{COUNT_W{1'b0}}, 1'b1};
    assign rreq_sum = {1'b0, rreq_reg} + {{COUNT_W{1'b0}}, in_token.req.recent_flag};
    assign pg_sum   = {1'b0, pg_reg}   + {{COUNT_W{1'b0}}, in_token.req.page_flag};
    assign rpg_sum  = {1'b0, rpg_reg}  + {{COUNT_W{1'b0}}, in_token.req.recent_page_flag};
    assign byt_sum  = {1'b0, byt_reg} +
                      {{(BYTE_W+1-AMOUNT_W){1'b0}}, in_token.req.byte_add};
    assign rbyt_sum = {1'b0, rbyt_reg} +
                      {{(BYTE_W+1-AMOUNT_W){1'b0}}, in_token.req.recent_byte_add};

    assign req_upd  = req_sum[COUNT_W]  ? '1 : req_sum[COUNT_W-1:0];
    assign rreq_upd = rreq_sum[COUNT_W] ? '1 : rreq_sum[COUNT_W-1:0];
    assign pg_upd   = pg_sum[COUNT_W]   ? '1 : pg_sum[COUNT_W-1:0];
    assign rpg_upd  = rpg_sum[COUNT_W]  ? '1 : rpg_sum[COUNT_W-1:0];
    assign byt_upd  = byt_sum[BYTE_W]   ? '1 : byt_sum[BYTE_W-1:0];
    assign rbyt_upd = rbyt_sum[BYTE_W]  ? '1 : rbyt_sum[BYTE_W-1:0];

    assign latest_upd   = (in_token.req.time_code > latest_reg) ?
                          in_token.req.time_code : latest_reg;
    assign earliest_upd = (in_token.req.time_code < earliest_reg) ?
                          in_token.req.time_code : earliest_reg;

    always_comb begin
        vld_next      = vld_reg;
        tok_next      = tok_reg;
        req_next      = req_reg;
        rreq_next     = rreq_reg;
        pg_next       = pg_reg;
        rpg_next      = rpg_reg;
        byt_next      = byt_reg;
        rbyt_next     = rbyt_reg;
        latest_next   = latest_reg;
        earliest_next = earliest_reg;
        if (in_ready) begin
            vld_next = in_valid;
        end
        if (load) begin
            tok_next = in_token;
        end
        if (claim) begin
            req_next      = req_upd;
            rreq_next     = rreq_upd;
            pg_next       = pg_upd;
            rpg_next      = rpg_upd;
            byt_next      = byt_upd;
            rbyt_next     = rbyt_upd;
            latest_next   = latest_upd;
            earliest_next = earliest_upd;
            tok_next.done                     = 1'b1;
            tok_next.res.bin_index            = IDX_OUT_W'(bin_id);
            tok_next.res.request_count        = req_upd;
            tok_next.res.recent_request_count = rreq_upd;
            tok_next.res.page_count           = pg_upd;
            tok_next.res.recent_page_count    = rpg_upd;
            tok_next.res.byte_total           = byt_upd;
            tok_next.res.recent_byte_total    = rbyt_upd;
            tok_next.res.latest_time          = latest_upd;
            tok_next.res.earliest_time        = earliest_upd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= 1'b0;
            req_reg      <= '0;
            rreq_reg     <= '0;
            pg_reg       <= '0;
            rpg_reg      <= '0;
            byt_reg      <= '0;
            rbyt_reg     <= '0;
            latest_reg   <= '0;
            earliest_reg <= '1;
        end else begin
            vld_reg      <= vld_next;
            req_reg      <= req_next;
            rreq_reg     <= rreq_next;
            pg_reg       <= pg_next;
            rpg_reg      <= rpg_next;
            byt_reg      <= byt_next;
            rbyt_reg     <= rbyt_next;
            latest_reg   <= latest_next;
            earliest_reg <= earliest_next;
        end
    end

    // payload stage, no reset needed
    always_ff @(posedge aclk) begin
        tok_reg <= tok_next;
    end

    assign out_valid = vld_reg;
    assign out_token = tok_reg;

endmodule

`default_nettype wire
